### hdl/vrm_pkg.sv
// ----------------------------------------------------------------------------
// vrm_pkg
// Shared types and constants of the variance ratio marker.
// ----------------------------------------------------------------------------
package vrm_pkg;

  // operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MLL,
    OP_MLH,
    OP_MHH
  } alu_op_t;

  // register indexes of the configuration channel
  localparam logic CFG_SHORT = 1'b0;
  localparam logic CFG_LONG  = 1'b1;

  // window lengths
  localparam int         WIN_BITS      = 9;
  localparam logic [8:0] SHORT_DEFAULT = 9'd16;
  localparam logic [8:0] LONG_DEFAULT  = 9'd64;
  localparam logic [8:0] SHORT_MIN     = 9'd2;

  // ratio output
  localparam int          FRAC_BITS  = 12;
  localparam logic [3:0]  IP_MAX     = 4'd10;
  localparam logic [3:0]  TEN        = 4'd10;
  localparam logic [15:0] MARKER_MAX = 16'd40960;

endpackage

### hdl/vrm_hist.sv
// ----------------------------------------------------------------------------
// vrm_hist
// Ring store of closing prices, one write and one registered read port.
// ----------------------------------------------------------------------------
module vrm_hist #(
  parameter int DEPTH = 257,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/vrm_alu.sv
// ----------------------------------------------------------------------------
// vrm_alu
// Shared wide add/subtract unit with a half-width multiplier for squares.
// ----------------------------------------------------------------------------
module vrm_alu #(
  parameter int PRICE_BITS = 32,
  parameter int W          = 128
) (
  input  vrm_pkg::alu_op_t        op,
  input  logic [W-1:0]            a,
  input  logic [W-1:0]            b,
  input  logic [PRICE_BITS-1:0]   mag,
  output logic [W-1:0]            y,
  output logic                    ge
);

  localparam int H = (PRICE_BITS + 1) / 2;

  logic [H-1:0]   lo;
  logic [H-1:0]   hi;
  logic [H-1:0]   mx;
  logic [H-1:0]   my;
  logic [2*H-1:0] prod;
  logic [W-1:0]   addend;
  logic           sub;
  logic [W:0]     sum;

  // split magnitude into halves
  assign lo = mag[H-1:0];
  assign hi = H'(mag >> H);

  // multiplier operand select
  always_comb begin
    mx = lo;
    my = lo;
    case (op)
      vrm_pkg::OP_MLH: begin
        my = hi;
      end
      vrm_pkg::OP_MHH: begin
        mx = hi;
        my = hi;
      end
      default: begin
        mx = lo;
        my = lo;
      end
    endcase
  end

  assign prod = mx * my;

  // addend select: partial products carry their weight
  always_comb begin
    sub    = 1'b0;
    addend = b;
    case (op)
      vrm_pkg::OP_MLL: addend = W'(prod);
      vrm_pkg::OP_MLH: addend = W'(prod) << (H + 1);
      vrm_pkg::OP_MHH: addend = W'(prod) << (2 * H);
      vrm_pkg::OP_SUB: begin
        sub    = 1'b1;
        addend = ~b;
      end
      default: addend = b;
    endcase
  end

  // one adder; carry out of a subtract means a >= b
  assign sum = {1'b0, a} + {1'b0, addend} + {{W{1'b0}}, sub};
  assign y   = sum[W-1:0];
  assign ge  = sum[W];

endmodule

### hdl/variance_ratio_marker.sv
// ----------------------------------------------------------------------------
// variance_ratio_marker
// Rolling variance ratio of bar-to-bar close differences, short vs long.
// Input stream: tdata = close_price, tuser = kind (0 append, 1 revise latest).
// Output stream: tdata = marker_size (12 fraction bits), tuser = long_flat.
// Config channel: cfg_index 0 short window, 1 long window; write when idle.
// No result until three bars are held. One transaction at a time: s_axis_tready
// is high only while the sequencer is idle. The shared multiply/add unit and
// its shift-add sequences run each item; the work grows with cs and cl, the
// differences in each window, and with ip, the integer part of the ratio. The
// result sits in an output register; a new input is taken while it waits, but
// the next result holds until the sink takes the last one. Reset clears the
// write slot and bar count and sets the windows to their defaults.
// ----------------------------------------------------------------------------
module variance_ratio_marker #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] close_price
  input  logic        s_axis_tuser,   // [0] kind
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] marker_size
  output logic        m_axis_tuser,   // [0] long_flat
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int SLW   = $clog2(DEPTH);
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = PRICE_BITS + CW + 1;
  localparam int W     = 2 * PRICE_BITS + CW + 50;
  localparam int CNTW  = $clog2(SW);
  localparam int CMPW  = (BW > vrm_pkg::WIN_BITS) ? BW : vrm_pkg::WIN_BITS;
  localparam int NB    = vrm_pkg::WIN_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_FIRST, ST_LD_FIRST, ST_DIFF, ST_MAC0, ST_MAC1, ST_MAC2,
    ST_QN2, ST_SQ, ST_SF, ST_NSUB, ST_MUL, ST_CHECK, ST_A2, ST_A3,
    ST_B1, ST_B2, ST_B3, ST_ABS, ST_ABS2, ST_DIV_INT, ST_DIV_FRAC, ST_DONE
  } state_t;

  state_t state;
  state_t mul_ret;

  logic [NB-1:0]         short_window;
  logic [NB-1:0]         long_window;
  logic [SLW-1:0]        write_slot;
  logic [BW-1:0]         bars_seen;

  logic [NB-1:0]         ns;
  logic [NB-1:0]         nl;
  logic [NB-1:0]         cl;
  logic [NB-1:0]         n_cur;
  logic [NB-1:0]         c_cur;
  logic                  win;
  logic [SLW-1:0]        head;
  logic [SLW-1:0]        ptr;
  logic [NB-1:0]         j;

  logic [PRICE_BITS-1:0] prev;
  logic [PRICE_BITS-1:0] mag;
  logic signed [SW-1:0]  s;
  logic [W-1:0]          q;
  logic [W-1:0]          na;
  logic [W-1:0]          nb;

  logic [W-1:0]          mul_x;
  logic [W-1:0]          mul_p;
  logic [SW-1:0]         mul_m;
  logic [CNTW-1:0]       mul_cnt;

  logic [3:0]            ip;
  logic [vrm_pkg::FRAC_BITS-1:0] frac;
  logic [3:0]            frac_cnt;
  logic [15:0]           res_size;
  logic                  res_flat;

  // accept-time signals
  logic                  in_accept;
  logic                  revise;
  logic [PRICE_BITS+31:0] price_ext;
  logic [PRICE_BITS-1:0] price;
  logic [SLW-1:0]        slot_prev;
  logic [SLW-1:0]        wr_addr;
  logic [BW-1:0]         bars_next;
  logic [BW-1:0]         bars_m1;
  logic [NB-1:0]         ns_eff;
  logic [NB-1:0]         nl_eff;
  logic [NB-1:0]         cs_next;
  logic [NB-1:0]         cl_next;

  // pass datapath
  logic [PRICE_BITS-1:0] rd_data;
  logic [PRICE_BITS:0]   r;
  logic [PRICE_BITS:0]   r_neg;
  logic [SW-1:0]         s_abs;
  logic [NB:0]           n_factor;
  logic [SLW-1:0]        ptr_dec;

  // shared unit
  vrm_pkg::alu_op_t      alu_op;
  logic [W-1:0]          alu_a;
  logic [W-1:0]          alu_b;
  logic [W-1:0]          alu_y;
  logic                  alu_ge;
  logic [vrm_pkg::FRAC_BITS-1:0] frac_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // price masked to the stored width
  assign price_ext = {{PRICE_BITS{1'b0}}, s_axis_tdata};
  assign price     = price_ext[PRICE_BITS-1:0];

  // ring write address and bar count
  assign revise    = s_axis_tuser && (bars_seen != '0);
  assign slot_prev = (write_slot == '0) ? SLW'(DEPTH - 1) : write_slot - 1'b1;
  assign wr_addr   = revise ? slot_prev : write_slot;
  assign bars_next = (revise || bars_seen == BW'(DEPTH)) ? bars_seen : bars_seen + 1'b1;
  assign bars_m1   = bars_next - 1'b1;

  // effective windows and difference counts
  assign ns_eff  = (short_window < vrm_pkg::SHORT_MIN) ? vrm_pkg::SHORT_DEFAULT : short_window;
  assign nl_eff  = ({1'b0, long_window} < ({1'b0, ns_eff} + 1'b1)) ?
                   vrm_pkg::LONG_DEFAULT : long_window;
  assign cs_next = (CMPW'(ns_eff) < CMPW'(bars_m1)) ? ns_eff : NB'(bars_m1);
  assign cl_next = (CMPW'(nl_eff) < CMPW'(bars_m1)) ? nl_eff : NB'(bars_m1);

  // difference of adjacent closes
  assign r        = {1'b0, prev} - {1'b0, rd_data};
  assign r_neg    = ~r + 1'b1;
  assign s_abs    = s[SW-1] ? SW'(-s) : SW'(s);
  assign n_factor = {n_cur, 1'b0} - {1'b0, c_cur};
  assign ptr_dec  = (ptr == '0) ? SLW'(DEPTH - 1) : ptr - 1'b1;

  vrm_hist #(
    .DEPTH (DEPTH),
    .DW    (PRICE_BITS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (wr_addr),
    .wr_data (price),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  // operand select for the shared unit
  always_comb begin
    alu_op = vrm_pkg::OP_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      ST_MAC0: begin
        alu_op = vrm_pkg::OP_MLL;
        alu_a  = q;
      end
      ST_MAC1: begin
        alu_op = vrm_pkg::OP_MLH;
        alu_a  = q;
      end
      ST_MAC2: begin
        alu_op = vrm_pkg::OP_MHH;
        alu_a  = q;
      end
      ST_MUL: begin
        alu_a = {mul_p[W-2:0], 1'b0};
        alu_b = mul_m[mul_cnt] ? mul_x : '0;
      end
      ST_NSUB: begin
        alu_op = vrm_pkg::OP_SUB;
        alu_a  = q;
        alu_b  = mul_p;
      end
      ST_ABS: begin
        alu_op = vrm_pkg::OP_SUB;
        alu_a  = na;
        alu_b  = mul_p;
      end
      ST_ABS2: begin
        alu_op = vrm_pkg::OP_SUB;
        alu_a  = nb;
        alu_b  = na;
      end
      ST_DIV_INT: begin
        alu_op = vrm_pkg::OP_SUB;
        alu_a  = mul_p;
        alu_b  = nb;
      end
      ST_DIV_FRAC: begin
        alu_op = vrm_pkg::OP_SUB;
        alu_a  = {mul_p[W-2:0], 1'b0};
        alu_b  = nb;
      end
      default: begin
        alu_op = vrm_pkg::OP_ADD;
      end
    endcase
  end

  vrm_alu #(
    .PRICE_BITS (PRICE_BITS),
    .W          (W)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .mag (mag),
    .y   (alu_y),
    .ge  (alu_ge)
  );

  assign frac_next = {frac[vrm_pkg::FRAC_BITS-2:0], alu_ge};

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      short_window  <= vrm_pkg::SHORT_DEFAULT;
      long_window   <= vrm_pkg::LONG_DEFAULT;
      write_slot    <= '0;
      bars_seen     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        if (cfg_index == vrm_pkg::CFG_SHORT) begin
          short_window <= cfg_data;
        end else begin
          long_window <= cfg_data;
        end
      end

      // the done state reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            bars_seen <= bars_next;
            if (!revise) begin
              write_slot <= (write_slot == SLW'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
            end
            head  <= wr_addr;
            ptr   <= wr_addr;
            ns    <= ns_eff;
            nl    <= nl_eff;
            cl    <= cl_next;
            n_cur <= ns_eff;
            c_cur <= cs_next;
            win   <= 1'b0;
            if (bars_next >= BW'(3)) begin
              state <= ST_RD_FIRST;
            end
          end
        end
        ST_RD_FIRST: begin
          ptr   <= ptr_dec;
          q     <= '0;
          s     <= '0;
          j     <= '0;
          state <= ST_LD_FIRST;
        end
        ST_LD_FIRST: begin
          prev  <= rd_data;
          ptr   <= ptr_dec;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          mag   <= r[PRICE_BITS] ? r_neg[PRICE_BITS-1:0] : r[PRICE_BITS-1:0];
          s     <= s + {{(SW-PRICE_BITS-1){r[PRICE_BITS]}}, r};
          prev  <= rd_data;
          j     <= j + 1'b1;
          state <= ST_MAC0;
        end
        ST_MAC0: begin
          q     <= alu_y;
          state <= ST_MAC1;
        end
        ST_MAC1: begin
          q     <= alu_y;
          state <= ST_MAC2;
        end
        ST_MAC2: begin
          q <= alu_y;
          if (j == c_cur) begin
            // q * n
            mul_x   <= alu_y;
            mul_m   <= SW'(n_cur);
            mul_cnt <= CNTW'(NB - 1);
            mul_p   <= '0;
            mul_ret <= ST_QN2;
            state   <= ST_MUL;
          end else begin
            ptr   <= ptr_dec;
            state <= ST_DIFF;
          end
        end
        ST_MUL: begin
          mul_p <= alu_y;
          if (mul_cnt == '0) begin
            state <= mul_ret;
          end else begin
            mul_cnt <= mul_cnt - 1'b1;
          end
        end
        ST_QN2: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(n_cur);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_SQ;
          state   <= ST_MUL;
        end
        ST_SQ: begin
          q       <= mul_p;
          mul_x   <= W'(s_abs);
          mul_m   <= s_abs;
          mul_cnt <= CNTW'(SW - 1);
          mul_p   <= '0;
          mul_ret <= ST_SF;
          state   <= ST_MUL;
        end
        ST_SF: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(n_factor);
          mul_cnt <= CNTW'(NB);
          mul_p   <= '0;
          mul_ret <= ST_NSUB;
          state   <= ST_MUL;
        end
        ST_NSUB: begin
          if (!win) begin
            na    <= alu_ge ? alu_y : '0;
            win   <= 1'b1;
            n_cur <= nl;
            c_cur <= cl;
            ptr   <= head;
            state <= ST_RD_FIRST;
          end else begin
            nb    <= alu_ge ? alu_y : '0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (nb == '0) begin
            res_size <= '0;
            res_flat <= 1'b1;
            state    <= ST_DONE;
          end else begin
            mul_x   <= na;
            mul_m   <= SW'(nl);
            mul_cnt <= CNTW'(NB - 1);
            mul_p   <= '0;
            mul_ret <= ST_A2;
            state   <= ST_MUL;
          end
        end
        ST_A2: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(nl);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_A3;
          state   <= ST_MUL;
        end
        ST_A3: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(nl);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_B1;
          state   <= ST_MUL;
        end
        ST_B1: begin
          na      <= mul_p;
          mul_x   <= nb;
          mul_m   <= SW'(ns);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_B2;
          state   <= ST_MUL;
        end
        ST_B2: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(ns);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_B3;
          state   <= ST_MUL;
        end
        ST_B3: begin
          mul_x   <= mul_p;
          mul_m   <= SW'(ns);
          mul_cnt <= CNTW'(NB - 1);
          mul_p   <= '0;
          mul_ret <= ST_ABS;
          state   <= ST_MUL;
        end
        ST_ABS: begin
          // nb now holds the scaled long term
          nb <= mul_p;
          if (alu_ge) begin
            mul_x   <= alu_y;
            mul_m   <= SW'(vrm_pkg::TEN);
            mul_cnt <= CNTW'(3);
            mul_p   <= '0;
            ip      <= '0;
            mul_ret <= ST_DIV_INT;
            state   <= ST_MUL;
          end else begin
            state <= ST_ABS2;
          end
        end
        ST_ABS2: begin
          mul_x   <= alu_y;
          mul_m   <= SW'(vrm_pkg::TEN);
          mul_cnt <= CNTW'(3);
          mul_p   <= '0;
          ip      <= '0;
          mul_ret <= ST_DIV_INT;
          state   <= ST_MUL;
        end
        ST_DIV_INT: begin
          if (ip == vrm_pkg::IP_MAX) begin
            res_size <= vrm_pkg::MARKER_MAX;
            res_flat <= 1'b0;
            state    <= ST_DONE;
          end else if (alu_ge) begin
            mul_p <= alu_y;
            ip    <= ip + 1'b1;
          end else begin
            frac     <= '0;
            frac_cnt <= '0;
            state    <= ST_DIV_FRAC;
          end
        end
        ST_DIV_FRAC: begin
          mul_p    <= alu_ge ? alu_y : {mul_p[W-2:0], 1'b0};
          frac     <= frac_next;
          frac_cnt <= frac_cnt + 1'b1;
          if (frac_cnt == 4'(vrm_pkg::FRAC_BITS - 1)) begin
            res_size <= {ip, frac_next};
            res_flat <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_size;
            m_axis_tuser  <= res_flat;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a new result only leaves the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside done state");

  // a flat long window forces a zero marker
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("flat long window with nonzero marker");

  // marker stays within its clamp
  a_marker_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata <= vrm_pkg::MARKER_MAX)
    else $error("marker above clamp");

  // integer part of the ratio never passes ten
  a_ip_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_INT |-> ip <= vrm_pkg::IP_MAX)
    else $error("integer quotient out of range");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the variance ratio marker: a behavioral predictor
// with exact wide arithmetic forms each expected marker, a scoreboard class
// compares every output transaction in order, and random gaps and stalls are
// applied on both streams across several window settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = 257;
  localparam int CYC_LIMIT = 4000000;

  typedef struct packed {
    logic [15:0] marker_size;
    logic        long_flat;
  } marker_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = vrm_pkg::CFG_SHORT;
  logic [8:0]  cfg_data = '0;

  int  cycles = 0;
  bit  sink_hold = 1'b0;
  bit  sink_busy_mode = 1'b0;

  variance_ratio_marker i_dut (.*);

  always #5 clk = ~clk;

  // scoreboard: closes ring, window registers, expected markers
  class marker_scoreboard;
    logic [31:0] closes[DEPTH];
    int          slot;
    int          bars;
    int          short_len;
    int          long_len;
    marker_t     pending[$];
    int          errors;

    function new();
      slot = 0; bars = 0; short_len = 16; long_len = 64; errors = 0;
    endfunction

    function void set_window(logic idx, logic [8:0] v);
      if (idx == vrm_pkg::CFG_SHORT) short_len = v;
      else long_len = v;
    endfunction

    function logic [31:0] prior(int j);
      return closes[(slot + 2 * DEPTH - 1 - j) % DEPTH];
    endfunction

    // n^2 * q - (2n - c) * s^2 over c latest differences; n^3 * population variance when c equals n
    function logic [255:0] scaled_var(int n, int c);
      logic [255:0] q, s2;
      logic signed [63:0] s, r;
      s = 0; q = 0;
      for (int j = 0; j < c; j++) begin
        r = $signed({32'd0, prior(j)}) - $signed({32'd0, prior(j + 1)});
        s += r;
        q += 256'(r < 0 ? -r : r) * 256'(r < 0 ? -r : r);
      end
      q = q * n * n;
      s2 = 256'(s < 0 ? -s : s);
      s2 = s2 * s2 * (2 * n - c);
      return (q < s2) ? 256'd0 : q - s2;
    endfunction

    function void note_input(logic kind, logic [31:0] price);
      int ns, nl, cs, cl, ip, frac;
      logic [255:0] a, b, d;
      marker_t m;
      if (kind && bars > 0) begin
        closes[(slot + DEPTH - 1) % DEPTH] = price;
      end else begin
        closes[slot] = price;
        slot = (slot + 1) % DEPTH;
        if (bars < DEPTH) bars++;
      end
      if (bars < 3) return;
      ns = short_len; nl = long_len;
      if (ns < 2) ns = 16;
      if (nl < ns + 1) nl = 64;
      cs = (ns < bars - 1) ? ns : bars - 1;
      cl = (nl < bars - 1) ? nl : bars - 1;
      a = scaled_var(ns, cs);
      b = scaled_var(nl, cl);
      if (b == 0) begin
        m.marker_size = 16'd0; m.long_flat = 1'b1;
      end else begin
        a = a * nl * nl * nl;
        b = b * ns * ns * ns;
        d = (a >= b) ? a - b : b - a;
        d = d * 10;
        ip = 0;
        while (ip < 10 && d >= b) begin
          d -= b; ip++;
        end
        if (ip >= 10) m.marker_size = vrm_pkg::MARKER_MAX;
        else begin
          frac = 0;
          for (int k = 0; k < vrm_pkg::FRAC_BITS; k++) begin
            d = d << 1;
            frac = frac << 1;
            if (d >= b) begin
              d -= b; frac |= 1;
            end
          end
          m.marker_size = 16'(ip * 4096 + frac);
        end
        m.long_flat = 1'b0;
      end
      pending.push_back(m);
    endfunction

    function void check_result(logic [15:0] size, logic flat);
      marker_t e;
      if (pending.size() == 0) begin
        $error("unexpected transaction: marker_size %0d long_flat %0d", size, flat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (size !== e.marker_size) begin
        $error("marker_size expected %0d actual %0d", e.marker_size, size);
        errors++;
      end
      if (flat !== e.long_flat) begin
        $error("long_flat expected %0d actual %0d", e.long_flat, flat);
        errors++;
      end
    endfunction
  endclass

  marker_scoreboard sb = new();

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // sample both streams at the rising edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (!rst && cfg_valid && cfg_ready) sb.set_window(cfg_index, cfg_data);
  end

  // output sink with random stalls
  always @(negedge clk) begin
    if (sink_hold) m_axis_tready <= 1'b0;
    else if (!sink_busy_mode) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    forever begin
      repeat (gap_len() * 50) @(negedge clk);
      sink_busy_mode = $urandom_range(0, 1);
    end
  end

  task automatic send_bar(logic kind, logic [31:0] price);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= price;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
  endtask

  task automatic write_window(logic idx, logic [8:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random bars: mostly walks, some big jumps and flat runs
  task automatic random_bars(int count, int mode);
    logic [31:0] p;
    p = $urandom();
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: p = $urandom();
        1, 2: p = p;
        default: p = p + $urandom_range(0, 40) - 20;
      endcase
      if (mode == 1) p = 32'd500 + $urandom_range(0, 1);
      send_bar($urandom_range(0, 4) == 0, p);
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  initial begin
    int shorts[6] = '{0, 1, 2, 16, 255, 256};
    int longs[6]  = '{0, 3, 64, 256, 511, 100};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: revise on empty, extremes, flat history, saturation
    send_bar(1'b1, 32'd0);
    send_bar(1'b0, 32'hFFFF_FFFF);
    send_bar(1'b0, 32'd0);
    send_bar(1'b1, 32'hFFFF_FFFF);
    send_bar(1'b0, 32'h5555_5555);
    send_bar(1'b0, 32'hAAAA_AAAA);
    for (int i = 0; i < 6; i++) send_bar(1'b0, 32'd7);
    send_bar(1'b1, 32'd9);
    for (int i = 0; i < 6; i++) send_bar(1'b0, 32'd100 * i);
    send_bar(1'b0, 32'h8000_0000);
    drain();

    // long receiver hold while the sender keeps going
    fork
      begin
        sink_hold = 1'b1;
        repeat (4000) @(negedge clk);
        sink_hold = 1'b0;
      end
      random_bars(8, 0);
    join
    drain();

    // window settings including extremes and fallbacks
    for (int k = 0; k < 6; k++) begin
      write_window(vrm_pkg::CFG_SHORT, 9'(shorts[k]));
      write_window(vrm_pkg::CFG_LONG, 9'(longs[k]));
      if (k == 1) random_bars(20, 1);
      random_bars(k == 4 ? 60 : 150, 0);
      drain();
    end
    write_window(vrm_pkg::CFG_SHORT, 9'd3);
    write_window(vrm_pkg::CFG_LONG, 9'd8);
    random_bars(150, 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### variance_ratio_marker.f
hdl/vrm_pkg.sv
hdl/vrm_hist.sv
hdl/vrm_alu.sv
hdl/variance_ratio_marker.sv
dv/testbench.sv
